>>> design/dmg_pkg.sv
// Shared types, constants and command/status structs of the maze generator.
package dmg_pkg;

  localparam int COL_BITS   = 5;
  localparam int ROW_BITS   = 5;
  localparam int MAX_COLUMNS = 1 << COL_BITS;
  localparam int MAX_ROWS    = 1 << ROW_BITS;
  localparam int CELL_BITS  = COL_BITS + ROW_BITS;
  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int DEPTH_BITS = CELL_BITS + 1;
  localparam int SIZE_BITS  = ((COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS) + 1;

  localparam int TW_N     = 312;
  localparam int TW_M     = 156;
  localparam int TW_ABITS = $clog2(TW_N);

  localparam logic [63:0] TW_MATRIX = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] TW_UPPER  = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] TW_LOWER  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] GOLDEN    = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] SEED_MULT = 64'd6364136223846793005;

  localparam logic [3:0] WALLS_ALL = 4'hF;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SEED   = 2'd2;

  localparam logic REQ_GENERATE = 1'b0;
  localparam logic REQ_READ     = 1'b1;

  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_SOUTH = 2'd1,
    DIR_WEST  = 2'd2,
    DIR_EAST  = 2'd3
  } dir_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_GEN_ACC,
    OP_START,
    OP_PROBE,
    OP_CUT_C_RD,
    OP_CUT_C_WR,
    OP_CUT_D_RD,
    OP_CUT_D_WR,
    OP_POP,
    OP_POP_LOAD,
    OP_FINISH,
    OP_RD_ISSUE,
    OP_RD_CAP
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic probe_done;
    logic has_cand;
    logic last_pop;
  } dp_sts_t;

  typedef struct packed {
    logic seed;
    logic draw;
  } tw_cmd_t;

  typedef struct packed {
    logic       busy;
    logic [1:0] index;
  } tw_sts_t;

endpackage

>>> design/dfs_maze_generator.sv
// Top level of the randomized depth-first maze generator with its cell-wall store.
//
// The block holds a 32 by 32 maze of wall bits. A generate transfer clears the store, seeds a
// 64-bit Mersenne Twister from base_seed XOR (level_index times the golden-ratio constant)
// and walks the maze depth-first from cell (0,0); its single result has generate_done set and
// all wall fields zero. A read transfer returns the four walls of one cell: the wall memory is
// read on acceptance and the result register is loaded in the read-wait state before the
// result is offered. After reset the block first runs a clearing pass over the wall and
// visited memories, one cell a cycle, and accepts no request until it ends; configuration
// writes are taken at any time the block is idle. A generate first seeds the twister (one
// shared 32 by 32 multiplier) alongside a new clearing pass, and then walks the area in use:
// each step of the walk probes the four neighbors through the single visited-memory read
// port, draws a number (with a modulo-three fold when three neighbors are open) and updates
// two cells of the wall memory read-modify-write, and every 312 draws the twister
// regenerates its state. One request is in flight at a time; the result waits in an output
// register until it is taken.
module dfs_maze_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [31:0] level_index_i,
  input  logic [4:0]  cell_x_i,
  input  logic [4:0]  cell_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        generate_done_o,
  output logic        wall_north_o,
  output logic        wall_south_o,
  output logic        wall_west_o,
  output logic        wall_east_o
);
  import dmg_pkg::*;

  // Configuration registers; the size is sampled when a generate transfer is accepted.
  logic [5:0]  width_q, height_q;
  logic [63:0] seed_q;

  dp_cmd_t    dp_cmd;
  dp_sts_t    dp_sts;
  tw_cmd_t    tw_cmd;
  tw_sts_t    tw_sts;
  logic [2:0] cand_count;
  logic [3:0] walls;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 6'd32;
      height_q <= 6'd32;
      seed_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_data_i[5:0];
        CFG_HEIGHT: height_q <= cfg_data_i[5:0];
        CFG_SEED:   seed_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dmg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (req_type_i),
    .out_ready_i (out_ready_i),
    .dp_sts_i    (dp_sts),
    .tw_sts_i    (tw_sts),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .dp_cmd_o    (dp_cmd),
    .tw_cmd_o    (tw_cmd)
  );

  dmg_twister u_twister (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (tw_cmd),
    .base_seed_i (seed_q),
    .level_i     (level_index_i),
    .count_i     (cand_count),
    .sts_o       (tw_sts)
  );

  dmg_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .width_i    (width_q),
    .height_i   (height_q),
    .cell_x_i   (cell_x_i),
    .cell_y_i   (cell_y_i),
    .tw_index_i (tw_sts.index),
    .count_o    (cand_count),
    .sts_o      (dp_sts),
    .gen_done_o (generate_done_o),
    .walls_o    (walls)
  );

  assign wall_north_o = walls[DIR_NORTH];
  assign wall_south_o = walls[DIR_SOUTH];
  assign wall_west_o  = walls[DIR_WEST];
  assign wall_east_o  = walls[DIR_EAST];

endmodule

>>> design/dmg_twister.sv
// 64-bit Mersenne Twister unit: seeding, lazy regeneration and a draw reduced modulo 1..4.
module dmg_twister (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dmg_pkg::tw_cmd_t cmd_i,
  input  logic [63:0]      base_seed_i,
  input  logic [31:0]      level_i,
  input  logic [2:0]       count_i,
  output dmg_pkg::tw_sts_t sts_o
);
  import dmg_pkg::*;

  typedef enum logic [14:0] {
    T_IDLE = 15'h0001,
    T_MIX0 = 15'h0002,
    T_MIX1 = 15'h0004,
    T_MIX2 = 15'h0008,
    T_SM0  = 15'h0010,
    T_SM1  = 15'h0020,
    T_SM2  = 15'h0040,
    T_SW   = 15'h0080,
    T_TA   = 15'h0100,
    T_TB   = 15'h0200,
    T_TC   = 15'h0400,
    T_TD   = 15'h0800,
    T_OR   = 15'h1000,
    T_OT   = 15'h2000,
    T_FOLD = 15'h4000
  } tw_state_e;

  function automatic logic [63:0] temper(input logic [63:0] v);
    logic [63:0] x;
    x = v;
    x = x ^ ((x >> 29) & 64'h5555_5555_5555_5555);
    x = x ^ ((x << 17) & 64'h71D6_7FFF_EDA6_0000);
    x = x ^ ((x << 37) & 64'hFFF7_EEE0_0000_0000);
    x = x ^ (x >> 43);
    return x;
  endfunction

  // Each fold keeps the value modulo 3 since every shift is even.
  function automatic logic [63:0] fold3(input logic [63:0] f, input logic [2:0] s);
    logic [63:0] r;
    case (s)
      3'd0:    r = 64'(f[63:32]) + 64'(f[31:0]);
      3'd1:    r = 64'(f[63:16]) + 64'(f[15:0]);
      3'd2:    r = 64'(f[63:8]) + 64'(f[7:0]);
      3'd3:    r = 64'(f[63:4]) + 64'(f[3:0]);
      default: r = 64'(f[63:2]) + 64'(f[1:0]);
    endcase
    return r;
  endfunction

  tw_state_e st_q, st_d;
  logic [TW_ABITS-1:0] i_q, i_d, pos_q, pos_d;
  logic [31:0] lvl_q, lvl_d, mx1_q, mx1_d, mx2_q, mx2_d;
  logic [63:0] p_q, p_d, mll_q, mll_d, a_q, a_d, b_q, b_d, f_q, f_d;
  logic [2:0]  fs_q, fs_d, cnt_q, cnt_d;
  logic [1:0]  idx_q, idx_d;

  logic [63:0] mem_q [TW_N];
  logic [63:0] rd_q;
  logic        mem_we;
  logic [TW_ABITS-1:0] mem_wa, mem_ra;
  logic [63:0] mem_wd;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] x_sm, y_tw, tw_v, seed_v, mix_v;
  logic [TW_ABITS-1:0] i1, im;
  logic [2:0]  r3;

  assign mul_p  = 64'(mul_a) * 64'(mul_b);
  assign x_sm   = p_q ^ (p_q >> 62);
  assign i1     = (i_q == TW_ABITS'(TW_N - 1)) ? '0 : i_q + 1'b1;
  assign im     = (i_q < TW_ABITS'(TW_N - TW_M)) ? i_q + TW_ABITS'(TW_M)
                                                 : i_q - TW_ABITS'(TW_N - TW_M);
  assign y_tw   = (a_q & TW_UPPER) | (b_q & TW_LOWER);
  assign tw_v   = rd_q ^ (y_tw >> 1) ^ (y_tw[0] ? TW_MATRIX : 64'h0);
  assign seed_v = mll_q + {mx1_q + mx2_q, 32'h0} + 64'(i_q);
  assign mix_v  = base_seed_i ^ (mll_q + {mx1_q, 32'h0});
  assign r3     = f_q[2:0];

  always_comb begin
    st_d   = st_q;
    i_d    = i_q;
    pos_d  = pos_q;
    lvl_d  = lvl_q;
    p_d    = p_q;
    mll_d  = mll_q;
    mx1_d  = mx1_q;
    mx2_d  = mx2_q;
    a_d    = a_q;
    b_d    = b_q;
    f_d    = f_q;
    fs_d   = fs_q;
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    mul_a  = x_sm[31:0];
    mul_b  = SEED_MULT[31:0];
    mem_we = 1'b0;
    mem_wa = i_q;
    mem_wd = seed_v;
    mem_ra = pos_q;
    case (st_q)
      T_IDLE: begin
        if (cmd_i.seed) begin
          lvl_d = level_i;
          st_d  = T_MIX0;
        end else if (cmd_i.draw) begin
          cnt_d = count_i;
          if (pos_q == TW_ABITS'(TW_N)) begin
            i_d  = '0;
            st_d = T_TA;
          end else begin
            st_d = T_OR;
          end
        end
      end
      T_MIX0: begin
        mul_a = lvl_q;
        mul_b = GOLDEN[31:0];
        mll_d = mul_p;
        st_d  = T_MIX1;
      end
      T_MIX1: begin
        mul_a = lvl_q;
        mul_b = GOLDEN[63:32];
        mx1_d = mul_p[31:0];
        st_d  = T_MIX2;
      end
      T_MIX2: begin
        mem_we = 1'b1;
        mem_wa = '0;
        mem_wd = mix_v;
        p_d    = mix_v;
        i_d    = TW_ABITS'(1);
        st_d   = T_SM0;
      end
      T_SM0: begin
        mll_d = mul_p;
        st_d  = T_SM1;
      end
      T_SM1: begin
        mul_b = SEED_MULT[63:32];
        mx1_d = mul_p[31:0];
        st_d  = T_SM2;
      end
      T_SM2: begin
        mul_a = x_sm[63:32];
        mx2_d = mul_p[31:0];
        st_d  = T_SW;
      end
      T_SW: begin
        mem_we = 1'b1;
        p_d    = seed_v;
        if (i_q == TW_ABITS'(TW_N - 1)) begin
          pos_d = TW_ABITS'(TW_N);
          st_d  = T_IDLE;
        end else begin
          i_d  = i_q + 1'b1;
          st_d = T_SM0;
        end
      end
      T_TA: begin
        mem_ra = i_q;
        st_d   = T_TB;
      end
      T_TB: begin
        mem_ra = i1;
        a_d    = rd_q;
        st_d   = T_TC;
      end
      T_TC: begin
        mem_ra = im;
        b_d    = rd_q;
        st_d   = T_TD;
      end
      T_TD: begin
        mem_we = 1'b1;
        mem_wd = tw_v;
        if (i_q == TW_ABITS'(TW_N - 1)) begin
          pos_d = '0;
          st_d  = T_OR;
        end else begin
          i_d  = i_q + 1'b1;
          st_d = T_TA;
        end
      end
      T_OR: begin
        st_d = T_OT;
      end
      T_OT: begin
        f_d   = temper(rd_q);
        pos_d = pos_q + 1'b1;
        fs_d  = '0;
        st_d  = T_FOLD;
      end
      T_FOLD: begin
        if (cnt_q == 3'd3 && fs_q != 3'd7) begin
          f_d  = fold3(f_q, fs_q);
          fs_d = fs_q + 1'b1;
        end else begin
          case (cnt_q)
            3'd2:    idx_d = {1'b0, f_q[0]};
            3'd3:    idx_d = (r3 >= 3'd3) ? 2'(r3 - 3'd3) : r3[1:0];
            3'd4:    idx_d = f_q[1:0];
            default: idx_d = 2'd0;
          endcase
          st_d = T_IDLE;
        end
      end
      default: st_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= T_IDLE;
      pos_q <= '0;
      i_q   <= '0;
    end else begin
      st_q  <= st_d;
      pos_q <= pos_d;
      i_q   <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d;
    p_q   <= p_d;
    mll_q <= mll_d;
    mx1_q <= mx1_d;
    mx2_q <= mx2_d;
    a_q   <= a_d;
    b_q   <= b_d;
    f_q   <= f_d;
    fs_q  <= fs_d;
    cnt_q <= cnt_d;
    idx_q <= idx_d;
  end

  assign sts_o.busy  = (st_q != T_IDLE);
  assign sts_o.index = idx_q;

endmodule

>>> design/dmg_datapath.sv
// Maze datapath: wall, visited and stack memories, walk registers and result register.
module dmg_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dmg_pkg::dp_cmd_t cmd_i,
  input  logic [5:0]       width_i,
  input  logic [5:0]       height_i,
  input  logic [4:0]       cell_x_i,
  input  logic [4:0]       cell_y_i,
  input  logic [1:0]       tw_index_i,
  output logic [2:0]       count_o,
  output dmg_pkg::dp_sts_t sts_o,
  output logic             gen_done_o,
  output logic [3:0]       walls_o
);
  import dmg_pkg::*;

  function automatic logic [SIZE_BITS-1:0] clamp(input logic [5:0] v, input int cap);
    logic [SIZE_BITS-1:0] r;
    if (v == 6'd0) begin
      r = SIZE_BITS'(1);
    end else if (32'(v) > cap) begin
      r = SIZE_BITS'(cap);
    end else begin
      r = SIZE_BITS'(v);
    end
    return r;
  endfunction

  function automatic logic [CELL_BITS-1:0] nbr(input logic [CELL_BITS-1:0] c, input dir_e d);
    logic [CELL_BITS-1:0] r;
    case (d)
      DIR_NORTH: r = c - CELL_BITS'(MAX_COLUMNS);
      DIR_SOUTH: r = c + CELL_BITS'(MAX_COLUMNS);
      DIR_WEST:  r = c - 1'b1;
      DIR_EAST:  r = c + 1'b1;
      default:   r = c;
    endcase
    return r;
  endfunction

  // Direction of the k-th open candidate, counted north, south, west, east.
  function automatic logic [1:0] kth(input logic [3:0] m, input logic [1:0] k);
    logic [2:0] seen;
    logic [1:0] r;
    seen = '0;
    r    = '0;
    for (int d = 0; d < 4; d++) begin
      if (m[d] && seen == {1'b0, k}) begin
        r = 2'(d);
      end
      if (m[d]) begin
        seen = seen + 1'b1;
      end
    end
    return r;
  endfunction

  logic [CELL_BITS-1:0]  clr_q, clr_d, cur_q, cur_d, dst_q, dst_d;
  logic [DEPTH_BITS-1:0] depth_q, depth_d;
  logic [SIZE_BITS-1:0]  w_q, w_d, h_q, h_d;
  logic [2:0]            pr_q, pr_d;
  logic [3:0]            mask_q, mask_d;
  logic [1:0]            dir_q, dir_d;
  logic                  in_store_q, in_store_d;
  logic                  gen_q, gen_d;
  logic [3:0]            res_q, res_d;

  logic [3:0]           walls_mem [CELL_COUNT];
  logic                 vis_mem   [CELL_COUNT];
  logic [CELL_BITS-1:0] stk_mem   [CELL_COUNT];
  logic [3:0]           wrd_q;
  logic                 vrd_q;
  logic [CELL_BITS-1:0] srd_q;

  logic                 w_we, v_we, v_wd, s_we;
  logic [CELL_BITS-1:0] w_wa, w_ra, v_wa, v_ra, s_wa, s_ra, s_wd;
  logic [3:0]           w_wd;

  logic [COL_BITS-1:0]  cur_x;
  logic [ROW_BITS-1:0]  cur_y;
  logic [3:0]           inr;
  logic [1:0]           pick, cap_dir;
  logic [DEPTH_BITS-1:0] below;

  assign cur_x   = cur_q[COL_BITS-1:0];
  assign cur_y   = cur_q[CELL_BITS-1:COL_BITS];
  assign inr[DIR_NORTH] = (cur_y != '0);
  assign inr[DIR_SOUTH] = (SIZE_BITS'(cur_y) + 1'b1) < h_q;
  assign inr[DIR_WEST]  = (cur_x != '0);
  assign inr[DIR_EAST]  = (SIZE_BITS'(cur_x) + 1'b1) < w_q;
  assign pick    = kth(mask_q, tw_index_i);
  assign cap_dir = 2'(pr_q - 3'd1);
  assign below   = depth_q - DEPTH_BITS'(2);

  always_comb begin
    clr_d      = clr_q;
    cur_d      = cur_q;
    dst_d      = dst_q;
    depth_d    = depth_q;
    w_d        = w_q;
    h_d        = h_q;
    pr_d       = '0;
    mask_d     = mask_q;
    dir_d      = dir_q;
    in_store_d = in_store_q;
    gen_d      = gen_q;
    res_d      = res_q;
    w_we = 1'b0;
    w_wa = clr_q;
    w_wd = WALLS_ALL;
    w_ra = cur_q;
    v_we = 1'b0;
    v_wa = clr_q;
    v_wd = 1'b0;
    v_ra = nbr(cur_q, dir_e'(pr_q[1:0]));
    s_we = 1'b0;
    s_wa = depth_q[CELL_BITS-1:0];
    s_wd = dst_q;
    s_ra = below[CELL_BITS-1:0];
    case (cmd_i.op)
      OP_CLEAR: begin
        w_we  = 1'b1;
        v_we  = 1'b1;
        clr_d = clr_q + 1'b1;
      end
      OP_GEN_ACC: begin
        w_d = clamp(width_i, MAX_COLUMNS);
        h_d = clamp(height_i, MAX_ROWS);
      end
      OP_START: begin
        v_we    = 1'b1;
        v_wa    = '0;
        v_wd    = 1'b1;
        s_we    = 1'b1;
        s_wa    = '0;
        s_wd    = '0;
        cur_d   = '0;
        depth_d = DEPTH_BITS'(1);
      end
      OP_PROBE: begin
        // Reads go out on steps 0..3, each answer is taken one step later.
        pr_d = pr_q + 1'b1;
        if (pr_q != 3'd0) begin
          mask_d[cap_dir] = inr[cap_dir] & ~vrd_q;
        end
      end
      OP_CUT_C_RD: begin
        dir_d = pick;
        dst_d = nbr(cur_q, dir_e'(pick));
      end
      OP_CUT_C_WR: begin
        w_we = 1'b1;
        w_wa = cur_q;
        w_wd = wrd_q & ~(4'b0001 << dir_q);
      end
      OP_CUT_D_RD: begin
        w_ra = dst_q;
      end
      OP_CUT_D_WR: begin
        w_we    = 1'b1;
        w_wa    = dst_q;
        w_wd    = wrd_q & ~(4'b0001 << (dir_q ^ 2'b01));
        v_we    = 1'b1;
        v_wa    = dst_q;
        v_wd    = 1'b1;
        s_we    = 1'b1;
        cur_d   = dst_q;
        depth_d = depth_q + 1'b1;
      end
      OP_POP: begin
        depth_d = depth_q - 1'b1;
      end
      OP_POP_LOAD: begin
        cur_d = srd_q;
      end
      OP_FINISH: begin
        depth_d = '0;
        gen_d   = 1'b1;
        res_d   = '0;
      end
      OP_RD_ISSUE: begin
        w_ra       = {ROW_BITS'(cell_y_i), COL_BITS'(cell_x_i)};
        in_store_d = (32'(cell_x_i) < MAX_COLUMNS) && (32'(cell_y_i) < MAX_ROWS);
      end
      OP_RD_CAP: begin
        gen_d = 1'b0;
        res_d = in_store_q ? wrd_q : WALLS_ALL;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      walls_mem[w_wa] <= w_wd;
    end
    wrd_q <= walls_mem[w_ra];
    if (v_we) begin
      vis_mem[v_wa] <= v_wd;
    end
    vrd_q <= vis_mem[v_ra];
    if (s_we) begin
      stk_mem[s_wa] <= s_wd;
    end
    srd_q <= stk_mem[s_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      depth_q <= '0;
      pr_q    <= '0;
    end else begin
      clr_q   <= clr_d;
      depth_q <= depth_d;
      pr_q    <= pr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    dst_q      <= dst_d;
    w_q        <= w_d;
    h_q        <= h_d;
    mask_q     <= mask_d;
    dir_q      <= dir_d;
    in_store_q <= in_store_d;
    gen_q      <= gen_d;
    res_q      <= res_d;
  end

  assign count_o          = 3'($countones(mask_q));
  assign sts_o.clr_last   = (clr_q == CELL_BITS'(CELL_COUNT - 1));
  assign sts_o.probe_done = (cmd_i.op == OP_PROBE) && (pr_q == 3'd4);
  assign sts_o.has_cand   = |mask_q;
  assign sts_o.last_pop   = (depth_q == DEPTH_BITS'(1));
  assign gen_done_o       = gen_q;
  assign walls_o          = res_q;

endmodule

>>> design/dmg_ctrl.sv
// Controller state machine that sequences clearing, seeding, the walk and cell reads.
module dmg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             req_type_i,
  input  logic             out_ready_i,
  input  dmg_pkg::dp_sts_t dp_sts_i,
  input  dmg_pkg::tw_sts_t tw_sts_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output dmg_pkg::dp_cmd_t dp_cmd_o,
  output dmg_pkg::tw_cmd_t tw_cmd_o
);
  import dmg_pkg::*;

  typedef enum logic [16:0] {
    S_CLEAR     = 17'h00001,
    S_IDLE      = 17'h00002,
    S_SEED_WAIT = 17'h00004,
    S_START     = 17'h00008,
    S_PROBE     = 17'h00010,
    S_DECIDE    = 17'h00020,
    S_DRAW      = 17'h00040,
    S_DRAW_WAIT = 17'h00080,
    S_CUT_C_RD  = 17'h00100,
    S_CUT_C_WR  = 17'h00200,
    S_CUT_D_RD  = 17'h00400,
    S_CUT_D_WR  = 17'h00800,
    S_POP       = 17'h01000,
    S_POP_WAIT  = 17'h02000,
    S_RD_WAIT   = 17'h04000,
    S_RESP      = 17'h08000,
    S_SPARE     = 17'h10000
  } ctrl_state_e;

  ctrl_state_e st_q, st_d;
  logic        gen_q, gen_d;

  always_comb begin
    st_d          = st_q;
    gen_d         = gen_q;
    dp_cmd_o.op   = OP_NONE;
    tw_cmd_o.seed = 1'b0;
    tw_cmd_o.draw = 1'b0;
    case (st_q)
      S_CLEAR: begin
        dp_cmd_o.op = OP_CLEAR;
        if (dp_sts_i.clr_last) begin
          st_d = gen_q ? S_SEED_WAIT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == REQ_GENERATE) begin
            dp_cmd_o.op   = OP_GEN_ACC;
            tw_cmd_o.seed = 1'b1;
            gen_d         = 1'b1;
            st_d          = S_CLEAR;
          end else begin
            dp_cmd_o.op = OP_RD_ISSUE;
            st_d        = S_RD_WAIT;
          end
        end
      end
      S_SEED_WAIT: begin
        if (!tw_sts_i.busy) begin
          st_d = S_START;
        end
      end
      S_START: begin
        dp_cmd_o.op = OP_START;
        st_d        = S_PROBE;
      end
      S_PROBE: begin
        dp_cmd_o.op = OP_PROBE;
        if (dp_sts_i.probe_done) begin
          st_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        st_d = dp_sts_i.has_cand ? S_DRAW : S_POP;
      end
      S_DRAW: begin
        tw_cmd_o.draw = 1'b1;
        st_d          = S_DRAW_WAIT;
      end
      S_DRAW_WAIT: begin
        if (!tw_sts_i.busy) begin
          st_d = S_CUT_C_RD;
        end
      end
      S_CUT_C_RD: begin
        dp_cmd_o.op = OP_CUT_C_RD;
        st_d        = S_CUT_C_WR;
      end
      S_CUT_C_WR: begin
        dp_cmd_o.op = OP_CUT_C_WR;
        st_d        = S_CUT_D_RD;
      end
      S_CUT_D_RD: begin
        dp_cmd_o.op = OP_CUT_D_RD;
        st_d        = S_CUT_D_WR;
      end
      S_CUT_D_WR: begin
        dp_cmd_o.op = OP_CUT_D_WR;
        st_d        = S_PROBE;
      end
      S_POP: begin
        if (dp_sts_i.last_pop) begin
          dp_cmd_o.op = OP_FINISH;
          gen_d       = 1'b0;
          st_d        = S_RESP;
        end else begin
          dp_cmd_o.op = OP_POP;
          st_d        = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        dp_cmd_o.op = OP_POP_LOAD;
        st_d        = S_PROBE;
      end
      S_RD_WAIT: begin
        dp_cmd_o.op = OP_RD_CAP;
        st_d        = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) begin
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_CLEAR;
      gen_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      gen_q <= gen_d;
    end
  end

  assign in_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = (st_q == S_RESP);

endmodule

>>> bench/tb_dfs_maze_generator.sv
// Self-checking testbench for the depth-first maze generator: stimulus, predictor and checks.
`timescale 1ns / 100ps

module tb_dfs_maze_generator;
  import dmg_pkg::*;

  // Wall bits of one cell as the result fields order them.
  localparam logic [3:0] BIT_NORTH = 4'd1;
  localparam logic [3:0] BIT_SOUTH = 4'd2;
  localparam logic [3:0] BIT_WEST  = 4'd4;
  localparam logic [3:0] BIT_EAST  = 4'd8;

  typedef struct packed {
    logic done;
    logic north;
    logic south;
    logic west;
    logic east;
  } maze_result_t;

  // Scoreboard: a cycle-free copy of the maze, the walk and the twister, plus the queue of
  // results still to arrive from the block.
  class maze_scoreboard;
    logic [63:0]  twister[TW_N];
    int           tw_pos;
    logic [3:0]   walls[CELL_COUNT];
    bit           seen[CELL_COUNT];
    int           path[CELL_COUNT];
    logic [5:0]   cols_cfg;
    logic [5:0]   rows_cfg;
    logic [63:0]  seed_cfg;
    maze_result_t awaited[$];
    int           errors;

    function new();
      cols_cfg = 6'd32;
      rows_cfg = 6'd32;
      seed_cfg = '0;
      errors   = 0;
      tw_pos   = 0;
      foreach (walls[i]) walls[i] = WALLS_ALL;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        CFG_WIDTH:  cols_cfg = data[5:0];
        CFG_HEIGHT: rows_cfg = data[5:0];
        CFG_SEED:   seed_cfg = data;
        default: ;
      endcase
    endfunction

    function void seed_twister(logic [63:0] s);
      logic [63:0] p;
      twister[0] = s;
      for (int i = 1; i < TW_N; i++) begin
        p = twister[i-1];
        twister[i] = SEED_MULT * (p ^ (p >> 62)) + 64'(i);
      end
      tw_pos = TW_N;
    endfunction

    function logic [63:0] draw();
      logic [63:0] y;
      logic [63:0] v;
      logic [63:0] x;
      if (tw_pos >= TW_N) begin
        for (int i = 0; i < TW_N; i++) begin
          y = (twister[i] & TW_UPPER) | (twister[(i + 1) % TW_N] & TW_LOWER);
          v = twister[(i + TW_M) % TW_N] ^ (y >> 1);
          if (y[0]) v = v ^ TW_MATRIX;
          twister[i] = v;
        end
        tw_pos = 0;
      end
      x = twister[tw_pos];
      tw_pos++;
      x = x ^ ((x >> 29) & 64'h5555555555555555);
      x = x ^ ((x << 17) & 64'h71D67FFFEDA60000);
      x = x ^ ((x << 37) & 64'hFFF7EEE000000000);
      x = x ^ (x >> 43);
      return x;
    endfunction

    function int clamp(logic [5:0] v, int cap);
      if (v == 0) return 1;
      if (int'(v) > cap) return cap;
      return int'(v);
    endfunction

    function void carve(logic [31:0] level);
      int cols;
      int rows;
      int depth;
      int c;
      int cx;
      int cy;
      int n;
      int k;
      int cand[4];
      logic [3:0] side[4];
      logic [3:0] back[4];
      cols = clamp(cols_cfg, MAX_COLUMNS);
      rows = clamp(rows_cfg, MAX_ROWS);
      seed_twister(seed_cfg ^ ({32'd0, level} * GOLDEN));
      foreach (walls[i]) begin
        walls[i] = WALLS_ALL;
        seen[i]  = 1'b0;
      end
      path[0] = 0;
      depth   = 1;
      seen[0] = 1'b1;
      while (depth > 0) begin
        c  = path[depth-1];
        cx = c % MAX_COLUMNS;
        cy = c / MAX_COLUMNS;
        n  = 0;
        if (cy > 0 && !seen[c - MAX_COLUMNS]) begin
          cand[n] = c - MAX_COLUMNS; side[n] = BIT_NORTH; back[n] = BIT_SOUTH; n++;
        end
        if (cy + 1 < rows && !seen[c + MAX_COLUMNS]) begin
          cand[n] = c + MAX_COLUMNS; side[n] = BIT_SOUTH; back[n] = BIT_NORTH; n++;
        end
        if (cx > 0 && !seen[c - 1]) begin
          cand[n] = c - 1; side[n] = BIT_WEST; back[n] = BIT_EAST; n++;
        end
        if (cx + 1 < cols && !seen[c + 1]) begin
          cand[n] = c + 1; side[n] = BIT_EAST; back[n] = BIT_WEST; n++;
        end
        if (n > 0) begin
          k = int'(draw() % 64'(n));
          walls[c]       = walls[c] & ~side[k];
          walls[cand[k]] = walls[cand[k]] & ~back[k];
          seen[cand[k]]  = 1'b1;
          if (depth < CELL_COUNT) begin
            path[depth] = cand[k];
            depth++;
          end
        end else begin
          depth--;
        end
      end
    endfunction

    // Called once per accepted request, in acceptance order.
    function void note_request(logic rt, logic [31:0] level, logic [4:0] x, logic [4:0] y);
      maze_result_t r;
      logic [3:0] w;
      if (rt == REQ_GENERATE) begin
        carve(level);
        r = '{done: 1'b1, north: 1'b0, south: 1'b0, west: 1'b0, east: 1'b0};
      end else begin
        w = walls[int'(y) * MAX_COLUMNS + int'(x)];
        r = '{done: 1'b0, north: w[0], south: w[1], west: w[2], east: w[3]};
      end
      awaited.push_back(r);
    endfunction

    function void check_result(maze_result_t got);
      maze_result_t exp_r;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %b with nothing outstanding", got);
        return;
      end
      exp_r = awaited.pop_front();
      if (got != exp_r) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch at %0t: expected done/N/S/W/E %b, got %b",
                   $realtime, exp_r, got);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_WIDTH;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        req_type_i = REQ_READ;
  logic [31:0] level_index_i = '0;
  logic [4:0]  cell_x_i = '0;
  logic [4:0]  cell_y_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        generate_done_o;
  logic        wall_north_o;
  logic        wall_south_o;
  logic        wall_west_o;
  logic        wall_east_o;

  maze_scoreboard sb = new();

  // Percent of requests before which the sender holds back, and of cycles in which the receiver does.
  int send_idle = 14;
  int recv_idle = 84;
  // Sizes of the last configuration, used to aim reads at the walked area.
  int cur_cols = 32;
  int cur_rows = 32;

  dfs_maze_generator dut (.*);

  always #10 clk_i = ~clk_i;

  // Offers one request and waits for its transfer. Starts and ends at a falling edge; valid
  // stays high between back-to-back requests.
  task automatic send_req(logic rt, logic [31:0] level, logic [4:0] x, logic [4:0] y);
    if ($urandom_range(99) < send_idle) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    req_type_i    = rt;
    level_index_i = level;
    cell_x_i      = x;
    cell_y_i      = y;
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(rt, level, x, y);
    @(negedge clk_i);
  endtask

  task automatic read_cell(logic [4:0] x, logic [4:0] y);
    send_req(REQ_READ, $urandom, x, y);
  endtask

  task automatic gen_maze(logic [31:0] level);
    send_req(REQ_GENERATE, level, 5'($urandom), 5'($urandom));
  endtask

  // Registers change only with nothing in flight; every request has a result, so an empty
  // queue means the block is idle.
  task automatic set_reg(logic [1:0] idx, logic [63:0] data);
    in_valid_i = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_size(logic [63:0] cols, logic [63:0] rows);
    set_reg(CFG_WIDTH, cols);
    set_reg(CFG_HEIGHT, rows);
    cur_cols = sb.clamp(cols[5:0], MAX_COLUMNS);
    cur_rows = sb.clamp(rows[5:0], MAX_ROWS);
  endtask

  // Mostly small mazes keep a generate short; now and then a size is zero or 32 to 63 so
  // that clamping is exercised.
  function automatic logic [63:0] pick_size();
    logic [63:0] v;
    v = {$urandom, $urandom} & ~64'h3F;
    case ($urandom_range(15))
      0:       v[5:0] = 6'd0;
      1:       v[5:0] = 6'($urandom_range(32, 63));
      2:       v[5:0] = 6'($urandom_range(9, 31));
      default: v[5:0] = 6'($urandom_range(1, 8));
    endcase
    return v;
  endfunction

  // One random sequence: at times new settings or a read, a generate, then reads mostly inside the maze.
  task automatic random_burst(ref int count);
    int reads;
    if ($urandom_range(3) != 0) set_size(pick_size(), pick_size());
    if ($urandom_range(2) == 0) set_reg(CFG_SEED, {$urandom, $urandom});
    if ($urandom_range(9) == 0) begin
      read_cell(5'($urandom), 5'($urandom));
      count++;
    end
    gen_maze($urandom);
    count++;
    reads = $urandom_range(3, 8);
    repeat (reads) begin
      if ($urandom_range(4) == 0)
        read_cell(5'($urandom), 5'($urandom));
      else
        read_cell(5'($urandom_range(cur_cols - 1)), 5'($urandom_range(cur_rows - 1)));
      count++;
    end
  endtask

  // Result side: take a transfer at the rising edge, then choose the next ready level at
  // the falling edge.
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_result('{done: generate_done_o, north: wall_north_o, south: wall_south_o,
                          west: wall_west_o, east: wall_east_o});
      @(negedge clk_i);
      out_ready_i = ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    int count;
    count = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Before any generate every cell reads with all four walls; the first transfer also
    // waits out the clearing pass that follows reset.
    read_cell(5'd0, 5'd0);
    read_cell(5'd31, 5'd31);
    // Full 32 by 32 maze with reset settings, then corners and an inner cell.
    gen_maze(32'd0);
    read_cell(5'd0, 5'd0);
    read_cell(5'd31, 5'd31);
    read_cell(5'd5, 5'd17);
    // Zero sizes behave as one cell: nothing to carve, all walls stay.
    set_size(64'd0, 64'hFFFF_FFFF_FFFF_FFC0);
    set_reg(CFG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
    gen_maze(32'hFFFF_FFFF);
    read_cell(5'd0, 5'd0);
    read_cell(5'd1, 5'd0);
    // Width past the store saturates; reads outside the rows in use keep all walls.
    set_size(64'd63, 64'd2);
    set_reg(CFG_SEED, {$urandom, $urandom});
    gen_maze(32'h8000_0001);
    read_cell(5'd31, 5'd1);
    read_cell(5'd0, 5'd1);
    read_cell(5'd3, 5'd5);
    // A single column, full height.
    set_size(64'd1, 64'd32);
    gen_maze($urandom);
    read_cell(5'd0, 5'd31);
    read_cell(5'd0, 5'd12);
    // Changing the size alone leaves the stored maze as it was.
    set_size(64'd4, 64'd4);
    read_cell(5'd0, 5'd20);
    read_cell(5'd0, 5'd31);
    read_cell(5'd1, 5'd0);
    count = 19;

    // Random sequences over three idling patterns.
    while (count < 60) random_burst(count);
    send_idle = 84;
    recv_idle = 14;
    while (count < 100) random_burst(count);
    send_idle = 0;
    recv_idle = 0;
    while (count < 140) random_burst(count);

    in_valid_i = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #(64'd5_000_000 * 20);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
